// ===== rtl/agkf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agkf_pkg: shared types, constants and arithmetic helpers
// Holds the port payload types, the arithmetic unit's request and response
// types, and the step program that the filter sequencer runs for each sample.
// ----------------------------------------------------------------------------
package agkf_pkg;

    // Port payloads.
    typedef struct packed {
        logic signed [31:0] accel_angle;
        logic signed [31:0] gyro_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] angle_out;
        logic signed [31:0] rate_out;
    } t_out_item;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TIME_STEP     = 3'd0,
        CFG_ANGLE_NOISE   = 3'd1,
        CFG_RATE_NOISE    = 3'd2,
        CFG_MEASURE_NOISE = 3'd3,
        CFG_GYRO_OFFSET   = 3'd4
    } t_cfg_idx;

    localparam int INT_FRAC = 24;
    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic signed [47:0] ONE_Q24 = 48'sh0000_0100_0000;
    // 180/pi in Q24.24.
    localparam logic signed [47:0] DEG_PER_RAD_Q24 = 48'sd961263669;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Operand sources and result destinations of the step program.
    typedef enum logic [4:0] {
        SRC_ZERO = 5'd0,
        SRC_ACC  = 5'd1,
        SRC_GYR  = 5'd2,
        SRC_OFF  = 5'd3,
        SRC_DT   = 5'd4,
        SRC_QA   = 5'd5,
        SRC_QG   = 5'd6,
        SRC_R    = 5'd7,
        SRC_ANG  = 5'd8,
        SRC_BIAS = 5'd9,
        SRC_DPR  = 5'd10,
        SRC_P00  = 5'd11,
        SRC_P01  = 5'd12,
        SRC_P10  = 5'd13,
        SRC_P11  = 5'd14,
        SRC_T    = 5'd15,
        SRC_TB   = 5'd16,
        SRC_PRED = 5'd17,
        SRC_ERR  = 5'd18,
        SRC_K0   = 5'd19,
        SRC_K1   = 5'd20
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        t_src dst;
        logic last;
    } t_step;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic signed [47:0] a;
        logic signed [47:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic signed [47:0] result;
    } t_alu_rsp;

    localparam int PROG_LEN = 30;
    localparam int PC_W = $clog2(PROG_LEN);

    function automatic t_step mk(t_op op, t_src dst, t_src a, t_src b, logic last);
        t_step s;
        s.op   = op;
        s.a    = a;
        s.b    = b;
        s.dst  = dst;
        s.last = last;
        return s;
    endfunction

    // One sample: predict, propagate covariance, find gains, correct.
    function automatic t_step prog_step(logic [PC_W-1:0] pc);
        t_step s;
        case (pc)
            5'd0:  s = mk(OP_SUB, SRC_T,    SRC_GYR,  SRC_OFF, 1'b0);
            5'd1:  s = mk(OP_MUL, SRC_T,    SRC_T,    SRC_DT,  1'b0);
            5'd2:  s = mk(OP_MUL, SRC_T,    SRC_T,    SRC_DPR, 1'b0);
            5'd3:  s = mk(OP_SUB, SRC_PRED, SRC_ANG,  SRC_T,   1'b0);
            5'd4:  s = mk(OP_SUB, SRC_T,    SRC_QA,   SRC_P01, 1'b0);
            5'd5:  s = mk(OP_SUB, SRC_T,    SRC_T,    SRC_P10, 1'b0);
            5'd6:  s = mk(OP_SUB, SRC_TB,   SRC_ZERO, SRC_P11, 1'b0);
            5'd7:  s = mk(OP_MUL, SRC_T,    SRC_T,    SRC_DT,  1'b0);
            5'd8:  s = mk(OP_ADD, SRC_P00,  SRC_P00,  SRC_T,   1'b0);
            5'd9:  s = mk(OP_MUL, SRC_T,    SRC_TB,   SRC_DT,  1'b0);
            5'd10: s = mk(OP_ADD, SRC_P01,  SRC_P01,  SRC_T,   1'b0);
            5'd11: s = mk(OP_ADD, SRC_P10,  SRC_P10,  SRC_T,   1'b0);
            5'd12: s = mk(OP_MUL, SRC_T,    SRC_QG,   SRC_DT,  1'b0);
            5'd13: s = mk(OP_ADD, SRC_P11,  SRC_P11,  SRC_T,   1'b0);
            5'd14: s = mk(OP_SUB, SRC_ERR,  SRC_ACC,  SRC_PRED, 1'b0);
            5'd15: s = mk(OP_ADD, SRC_TB,   SRC_R,    SRC_P00, 1'b0);
            5'd16: s = mk(OP_DIV, SRC_K0,   SRC_P00,  SRC_TB,  1'b0);
            5'd17: s = mk(OP_DIV, SRC_K1,   SRC_P10,  SRC_TB,  1'b0);
            // Gain corrections use the covariance before correction, so the
            // rows are ordered such that each old entry is read before it changes.
            5'd18: s = mk(OP_MUL, SRC_T,    SRC_K1,   SRC_P00, 1'b0);
            5'd19: s = mk(OP_SUB, SRC_P10,  SRC_P10,  SRC_T,   1'b0);
            5'd20: s = mk(OP_MUL, SRC_T,    SRC_K1,   SRC_P01, 1'b0);
            5'd21: s = mk(OP_SUB, SRC_P11,  SRC_P11,  SRC_T,   1'b0);
            5'd22: s = mk(OP_MUL, SRC_T,    SRC_K0,   SRC_P01, 1'b0);
            5'd23: s = mk(OP_SUB, SRC_P01,  SRC_P01,  SRC_T,   1'b0);
            5'd24: s = mk(OP_MUL, SRC_T,    SRC_K0,   SRC_P00, 1'b0);
            5'd25: s = mk(OP_SUB, SRC_P00,  SRC_P00,  SRC_T,   1'b0);
            5'd26: s = mk(OP_MUL, SRC_T,    SRC_K1,   SRC_ERR, 1'b0);
            5'd27: s = mk(OP_ADD, SRC_TB,   SRC_BIAS, SRC_T,   1'b0);
            5'd28: s = mk(OP_MUL, SRC_T,    SRC_K0,   SRC_ERR, 1'b0);
            5'd29: s = mk(OP_ADD, SRC_PRED, SRC_PRED, SRC_T,   1'b1);
            default: s = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b1);
        endcase
        return s;
    endfunction

    function automatic logic [47:0] mag48(logic signed [47:0] v);
        return v[47] ? (48'd0 - 48'(v)) : 48'(v);
    endfunction

    function automatic logic signed [47:0] sat48(logic signed [48:0] s);
        logic signed [47:0] r;
        if (s[48] != s[47]) begin
            r = s[48] ? MIN48 : MAX48;
        end else begin
            r = s[47:0];
        end
        return r;
    endfunction

    // Applies a sign to a magnitude and saturates to the 48-bit range.
    function automatic logic signed [47:0] sat_sign(logic [72:0] m, logic neg);
        logic signed [47:0] r;
        if (neg) begin
            r = (m > 73'h8000_0000_0000) ? MIN48 : (48'd0 - m[47:0]);
        end else begin
            r = (m > 73'h7FFF_FFFF_FFFF) ? MAX48 : m[47:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/angle_gyro_kalman_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter: two-state tilt angle and gyro bias filter
// Fixed-point Kalman filter fusing an accelerometer angle with a gyro rate.
// ----------------------------------------------------------------------------
// Each request brings an accelerometer angle in degrees and a gyro rate in
// rad/s, both signed with FRAC_BITS fraction bits, and gives one result: the
// filtered angle and the gyro rate minus the estimated bias. All internal math
// is saturating Q24.24 in 48 bits, run as a 30-step program on one shared
// arithmetic unit; the two gain divisions dominate the run time. The input
// is stalled while the program runs and until the result can move into the
// output register.
// Configuration writes are taken at any time, but are meant for idle periods.
// Reset sets both estimates to zero and the covariance to identity.
module angle_gyro_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  agkf_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output agkf_pkg::t_out_item  o_out_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [2:0]           i_cfg_index,
    input  wire  [31:0]          i_cfg_data
);

    localparam int UP_SHIFT = agkf_pkg::INT_FRAC - FRAC_BITS;
    localparam logic [48:0] HALF = 49'((64'd1 << UP_SHIFT) >> 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [agkf_pkg::PC_W-1:0] r_pc, n_pc;

    logic [15:0]        r_time_step;
    logic [30:0]        r_angle_noise, r_rate_noise, r_measure_noise;
    logic signed [31:0] r_gyro_offset;

    logic signed [31:0] r_accel, r_gyro;
    logic signed [31:0] r_angle_est, r_bias_est;
    logic signed [47:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [47:0] r_t, r_tb, r_pred, r_err, r_k0, r_k1;

    logic               r_out_valid;
    agkf_pkg::t_out_item r_out;

    agkf_pkg::t_step    w_step;
    agkf_pkg::t_alu_req w_req;
    agkf_pkg::t_alu_rsp w_rsp;
    logic               w_in_take, w_emit;
    logic signed [31:0] w_new_angle, w_new_bias;
    logic [32:0]        w_rate_diff;
    logic signed [31:0] w_rate;

    function automatic logic signed [47:0] to_q24(logic signed [31:0] v);
        return {{16{v[31]}}, v} << UP_SHIFT;
    endfunction

    function automatic logic signed [47:0] to_q24u(logic [31:0] v);
        return {16'd0, v} << UP_SHIFT;
    endfunction

    // Round to nearest, ties away from zero, then saturate to 32 bits.
    function automatic logic signed [31:0] narrow(logic signed [47:0] v);
        logic [48:0] m;
        logic signed [31:0] r;
        m = ({1'b0, agkf_pkg::mag48(v)} + HALF) >> UP_SHIFT;
        if (v[47]) begin
            r = (m > 49'h0_8000_0000) ? 32'sh8000_0000 : (32'd0 - m[31:0]);
        end else begin
            r = (m > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] pick(agkf_pkg::t_src s);
        logic signed [47:0] v;
        case (s)
            agkf_pkg::SRC_ZERO: v = '0;
            agkf_pkg::SRC_ACC:  v = to_q24(r_accel);
            agkf_pkg::SRC_GYR:  v = to_q24(r_gyro);
            agkf_pkg::SRC_OFF:  v = to_q24(r_gyro_offset);
            agkf_pkg::SRC_DT:   v = to_q24u({16'd0, r_time_step});
            agkf_pkg::SRC_QA:   v = to_q24u({1'b0, r_angle_noise});
            agkf_pkg::SRC_QG:   v = to_q24u({1'b0, r_rate_noise});
            agkf_pkg::SRC_R:    v = to_q24u({1'b0, r_measure_noise});
            agkf_pkg::SRC_ANG:  v = to_q24(r_angle_est);
            agkf_pkg::SRC_BIAS: v = to_q24(r_bias_est);
            agkf_pkg::SRC_DPR:  v = agkf_pkg::DEG_PER_RAD_Q24;
            agkf_pkg::SRC_P00:  v = r_p00;
            agkf_pkg::SRC_P01:  v = r_p01;
            agkf_pkg::SRC_P10:  v = r_p10;
            agkf_pkg::SRC_P11:  v = r_p11;
            agkf_pkg::SRC_T:    v = r_t;
            agkf_pkg::SRC_TB:   v = r_tb;
            agkf_pkg::SRC_PRED: v = r_pred;
            agkf_pkg::SRC_ERR:  v = r_err;
            agkf_pkg::SRC_K0:   v = r_k0;
            agkf_pkg::SRC_K1:   v = r_k1;
            default:            v = '0;
        endcase
        return v;
    endfunction

    agkf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_step      = agkf_pkg::prog_step(r_pc);
        w_req.start = (r_state == ST_ISSUE);
        w_req.op    = w_step.op;
        w_req.a     = pick(w_step.a);
        w_req.b     = pick(w_step.b);

        w_in_take   = (r_state == ST_IDLE) && i_in_valid;
        w_emit      = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

        w_new_angle = narrow(r_pred);
        w_new_bias  = narrow(r_tb);
        w_rate_diff = {r_gyro[31], r_gyro} - {w_new_bias[31], w_new_bias};
        if (w_rate_diff[32] != w_rate_diff[31]) begin
            w_rate = w_rate_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_rate = w_rate_diff[31:0];
        end

        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_state = ST_ISSUE;
                    n_pc    = '0;
                end
            end
            ST_ISSUE: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_rsp.done) begin
                    if (w_step.last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ISSUE;
                        n_pc    = r_pc + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_pc            <= '0;
            r_out_valid     <= 1'b0;
            r_time_step     <= 16'd328;
            r_angle_noise   <= 31'd65536;
            r_rate_noise    <= 31'd65536;
            r_measure_noise <= 31'd327680000;
            r_gyro_offset   <= '0;
            r_angle_est     <= '0;
            r_bias_est      <= '0;
            r_p00           <= agkf_pkg::ONE_Q24;
            r_p01           <= '0;
            r_p10           <= '0;
            r_p11           <= agkf_pkg::ONE_Q24;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    agkf_pkg::CFG_TIME_STEP:     r_time_step     <= i_cfg_data[15:0];
                    agkf_pkg::CFG_ANGLE_NOISE:   r_angle_noise   <= i_cfg_data[30:0];
                    agkf_pkg::CFG_RATE_NOISE:    r_rate_noise    <= i_cfg_data[30:0];
                    agkf_pkg::CFG_MEASURE_NOISE: r_measure_noise <= i_cfg_data[30:0];
                    agkf_pkg::CFG_GYRO_OFFSET:   r_gyro_offset   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if ((r_state == ST_WAIT) && w_rsp.done) begin
                case (w_step.dst)
                    agkf_pkg::SRC_P00: r_p00 <= w_rsp.result;
                    agkf_pkg::SRC_P01: r_p01 <= w_rsp.result;
                    agkf_pkg::SRC_P10: r_p10 <= w_rsp.result;
                    agkf_pkg::SRC_P11: r_p11 <= w_rsp.result;
                    default: begin
                    end
                endcase
            end

            if (w_emit) begin
                r_angle_est <= w_new_angle;
                r_bias_est  <= w_new_bias;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_in_take) begin
            r_accel <= i_in_data.accel_angle;
            r_gyro  <= i_in_data.gyro_rate;
        end

        if ((r_state == ST_WAIT) && w_rsp.done) begin
            case (w_step.dst)
                agkf_pkg::SRC_T:    r_t    <= w_rsp.result;
                agkf_pkg::SRC_TB:   r_tb   <= w_rsp.result;
                agkf_pkg::SRC_PRED: r_pred <= w_rsp.result;
                agkf_pkg::SRC_ERR:  r_err  <= w_rsp.result;
                agkf_pkg::SRC_K0:   r_k0   <= w_rsp.result;
                agkf_pkg::SRC_K1:   r_k1   <= w_rsp.result;
                default: begin
                end
            endcase
        end

        if (w_emit) begin
            r_out.angle_out <= w_new_angle;
            r_out.rate_out  <= w_rate;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/agkf_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agkf_alu: shared saturating Q24.24 arithmetic unit
// Add and subtract with the result registered, multiply from four 24x24
// partial products, divide by restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module agkf_alu (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  agkf_pkg::t_alu_req  i_req,
    output agkf_pkg::t_alu_rsp  o_rsp
);

    localparam int DIV_STEPS = 72;

    logic               r_busy, n_busy;
    agkf_pkg::t_op      r_op, n_op;
    logic [6:0]         r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic [47:0]        r_ma, n_ma;
    logic [47:0]        r_mb, n_mb;
    logic [96:0]        r_acc, n_acc;
    logic [47:0]        r_prod, n_prod;
    logic [47:0]        r_rem, n_rem;
    logic [47:0]        r_q, n_q;
    logic               r_ovf, n_ovf;
    logic [71:0]        r_dvd, n_dvd;
    logic               r_done, n_done;
    logic signed [47:0] r_res, n_res;

    logic [23:0] w_pa, w_pb;
    logic [48:0] w_trial;
    logic [48:0] w_sum;
    logic [72:0] w_qm;

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    always_comb begin
        w_pa    = r_cnt[2] ? r_ma[47:24] : r_ma[23:0];
        w_pb    = r_cnt[1] ? r_mb[47:24] : r_mb[23:0];
        w_trial = {r_rem, r_dvd[71]};
        w_qm    = (r_ovf || r_q[47]) ? 73'h1_0000_0000_0000 : {25'd0, r_q};
        if (i_req.op == agkf_pkg::OP_SUB) begin
            w_sum = {i_req.a[47], i_req.a} - {i_req.b[47], i_req.b};
        end else begin
            w_sum = {i_req.a[47], i_req.a} + {i_req.b[47], i_req.b};
        end

        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_acc  = r_acc;
        n_prod = r_prod;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        n_dvd  = r_dvd;
        n_done = 1'b0;
        n_res  = r_res;

        if (!r_busy && i_req.start) begin
            n_op  = i_req.op;
            n_neg = i_req.a[47] ^ i_req.b[47];
            n_ma  = agkf_pkg::mag48(i_req.a);
            n_mb  = agkf_pkg::mag48(i_req.b);
            n_cnt = '0;
            case (i_req.op)
                agkf_pkg::OP_ADD, agkf_pkg::OP_SUB: begin
                    n_res  = agkf_pkg::sat48($signed(w_sum));
                    n_done = 1'b1;
                end
                agkf_pkg::OP_MUL: begin
                    // Rounding constant for the final drop of 24 fraction bits.
                    n_acc  = 97'd1 << (agkf_pkg::INT_FRAC - 1);
                    n_busy = 1'b1;
                end
                agkf_pkg::OP_DIV: begin
                    if (i_req.b == '0) begin
                        n_res  = '0;
                        n_done = 1'b1;
                    end else begin
                        n_dvd  = {agkf_pkg::mag48(i_req.a), 24'd0};
                        n_rem  = '0;
                        n_q    = '0;
                        n_ovf  = 1'b0;
                        n_busy = 1'b1;
                    end
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end else if (r_busy) begin
            if (r_op == agkf_pkg::OP_MUL) begin
                if (r_cnt == 7'd8) begin
                    n_res  = agkf_pkg::sat_sign(r_acc[96:24], r_neg);
                    n_done = 1'b1;
                    n_busy = 1'b0;
                end else begin
                    if (!r_cnt[0]) begin
                        n_prod = w_pa * w_pb;
                    end else begin
                        case ({1'b0, r_cnt[2]} + {1'b0, r_cnt[1]})
                            2'd0:    n_acc = r_acc + {49'd0, r_prod};
                            2'd1:    n_acc = r_acc + {25'd0, r_prod, 24'd0};
                            default: n_acc = r_acc + {1'b0, r_prod, 48'd0};
                        endcase
                    end
                    n_cnt = r_cnt + 7'd1;
                end
            end else begin
                if (r_cnt == 7'(DIV_STEPS)) begin
                    n_res  = agkf_pkg::sat_sign(w_qm, r_neg);
                    n_done = 1'b1;
                    n_busy = 1'b0;
                end else begin
                    if (w_trial >= {1'b0, r_mb}) begin
                        n_rem = 48'(w_trial - {1'b0, r_mb});
                        n_q   = {r_q[46:0], 1'b1};
                    end else begin
                        n_rem = w_trial[47:0];
                        n_q   = {r_q[46:0], 1'b0};
                    end
                    // Any quotient bit at or above bit 47 means saturation.
                    n_ovf = r_ovf | r_q[47];
                    n_dvd = {r_dvd[70:0], 1'b0};
                    n_cnt = r_cnt + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_ovf  <= n_ovf;
        r_dvd  <= n_dvd;
        r_res  <= n_res;
    end

endmodule
`default_nettype wire
